>>> hw/rtl/linear_upsampler_to_48khz_core_defines.svh
// Assertion macros used by the upsampler core.
`ifndef LINEAR_UPSAMPLER_TO_48KHZ_CORE_DEFINES_SVH
`define LINEAR_UPSAMPLER_TO_48KHZ_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// expr holds at every clock edge out of reset
`define LU48_ASSERT_HOLDS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("lu48 invariant violated");

// cons holds in the same cycle as ante
`define LU48_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lu48 implication violated");

// cons holds in the cycle after ante
`define LU48_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lu48 sequence violated");

`else

`define LU48_ASSERT_HOLDS(label, clk, rst_n, expr)
`define LU48_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define LU48_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/lu48_pkg.sv
// Types and constants of the linear 48 kHz upsampler.
`default_nettype none

package lu48_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int RATE_W    = 16;
    localparam int ACC_W     = 17;
    localparam int COUNT_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // divider operand widths: magnitude of a sample difference over the split count
    localparam int DIV_NUM_W = 16;
    localparam int DIV_DEN_W = COUNT_W;

    localparam logic [ACC_W-1:0]  OUT_RATE_ACC = ACC_W'(48000);
    localparam logic [RATE_W-1:0] RATE_MAX     = RATE_W'(48000);
    localparam logic [RATE_W-1:0] RATE_MIN     = RATE_W'(1500);
    localparam logic [RATE_W-1:0] RATE_RESET   = RATE_W'(44100);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MONO_MODE   = CFG_IDX_W'(1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic                       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
        logic [DIV_DEN_W-1:0] rem;
    } t_div_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PHASE,
        ST_LOAD_L,
        ST_WAIT_L,
        ST_LOAD_R,
        ST_WAIT_R,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/linear_upsampler_to_48khz_core.sv
// Sequence: accept a frame, step the phase adder until it wraps, then with a nonzero split
// count divide the left and then the right difference (left only in mono) and emit count+1
// results; a zero split count gives one result.
// Frames: one at a time; a new frame is taken only after the last result of the previous
// one is loaded into the output register, so output stalls hold the input too.
// Reset: synchronous, active low; rate 44100, stereo, phase and previous frame zero.
`default_nettype none
`include "linear_upsampler_to_48khz_core_defines.svh"

module linear_upsampler_to_48khz_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // input frames
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire  lu48_pkg::t_in_item            i_in_data,
    // output frames
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output lu48_pkg::t_out_item                 o_out_data,
    // configuration writes
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [lu48_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [lu48_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    localparam int SW = lu48_pkg::SAMPLE_W;
    localparam int CW = lu48_pkg::COUNT_W;
    localparam int NW = lu48_pkg::DIV_NUM_W;

    lu48_pkg::t_state r_state, n_state;

    // configuration
    logic [lu48_pkg::RATE_W-1:0] r_rate;
    logic                        r_mono;

    // persistent state
    logic [lu48_pkg::RATE_W-1:0] r_phase;
    logic signed [SW-1:0]        r_prev_l, r_prev_r;

    // per-frame working registers
    logic signed [SW-1:0]        r_cur_l, r_cur_r;
    logic                        r_neg_l, r_neg_r;
    logic [NW-1:0]               r_mag_l, r_mag_r;
    logic [lu48_pkg::ACC_W-1:0]  r_acc;
    logic [CW-1:0]               r_adds;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_m;
    logic [NW-1:0]               r_qd_l, r_qd_r;
    logic [CW-1:0]               r_rd_l, r_rd_r;
    logic [NW-1:0]               r_q_l, r_q_r;
    logic [CW-1:0]               r_r_l, r_r_r;

    // output register
    logic                        r_out_valid;
    lu48_pkg::t_out_item         r_out;

    // FSM outputs
    logic                        in_take;
    logic                        out_load;
    lu48_pkg::t_div_req          div_req;
    lu48_pkg::t_div_rsp          div_rsp;

    // combinational helpers
    logic signed [SW:0]          diff_l, diff_r;
    logic signed [SW-1:0]        in_r;
    logic [lu48_pkg::ACC_W-1:0]  acc_sum;
    logic                        acc_wrap;
    logic                        is_last;
    lu48_pkg::t_out_item         emit_item;
    logic [CW:0]                 rs_l, rs_r;
    logic                        wrap_l, wrap_r;
    logic signed [SW:0]          ofs_l, ofs_r;
    logic                        div_wait;
    logic                        run_end;

    // configuration writes, rate saturated to the legal range
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= lu48_pkg::RATE_RESET;
            r_mono <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                lu48_pkg::CFG_SOURCE_RATE: begin
                    if (i_cfg_data > lu48_pkg::RATE_MAX) begin
                        r_rate <= lu48_pkg::RATE_MAX;
                    end else if (i_cfg_data < lu48_pkg::RATE_MIN) begin
                        r_rate <= lu48_pkg::RATE_MIN;
                    end else begin
                        r_rate <= i_cfg_data;
                    end
                end
                lu48_pkg::CFG_MONO_MODE: r_mono <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input differences against the previous frame
    always_comb begin
        in_r   = r_mono ? '0 : i_in_data.right_sample;
        diff_l = {i_in_data.left_sample[SW-1], i_in_data.left_sample} - {r_prev_l[SW-1], r_prev_l};
        diff_r = {in_r[SW-1], in_r} - {r_prev_r[SW-1], r_prev_r};
    end

    // phase accumulator step
    always_comb begin
        acc_sum  = r_acc + {1'b0, r_rate};
        acc_wrap = (acc_sum >= lu48_pkg::OUT_RATE_ACC);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lu48_pkg::ST_IDLE:   if (i_in_valid) n_state = lu48_pkg::ST_PHASE;
            lu48_pkg::ST_PHASE: begin
                if (acc_wrap) begin
                    n_state = (r_adds == '0) ? lu48_pkg::ST_EMIT : lu48_pkg::ST_LOAD_L;
                end
            end
            lu48_pkg::ST_LOAD_L: n_state = lu48_pkg::ST_WAIT_L;
            lu48_pkg::ST_WAIT_L: begin
                if (div_rsp.done) begin
                    n_state = r_mono ? lu48_pkg::ST_EMIT : lu48_pkg::ST_LOAD_R;
                end
            end
            lu48_pkg::ST_LOAD_R: n_state = lu48_pkg::ST_WAIT_R;
            lu48_pkg::ST_WAIT_R: if (div_rsp.done) n_state = lu48_pkg::ST_EMIT;
            lu48_pkg::ST_EMIT:   if (out_load && is_last) n_state = lu48_pkg::ST_IDLE;
            default:             n_state = lu48_pkg::ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        o_in_stall       = 1'b1;
        in_take          = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = r_mag_l;
        div_req.divisor  = r_count;
        unique case (r_state)
            lu48_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                in_take    = i_in_valid;
            end
            lu48_pkg::ST_LOAD_L: div_req.start = 1'b1;
            lu48_pkg::ST_LOAD_R: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_mag_r;
            end
            lu48_pkg::ST_EMIT: out_load = !r_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lu48_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    lu48_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // result of the current step; signed offset is the truncated quotient
    always_comb begin
        is_last = (r_m == r_count);
        ofs_l   = r_neg_l ? -$signed({1'b0, r_q_l}) : $signed({1'b0, r_q_l});
        ofs_r   = r_neg_r ? -$signed({1'b0, r_q_r}) : $signed({1'b0, r_q_r});
        if (r_count == '0) begin
            emit_item.left_out  = r_cur_l;
            emit_item.right_out = r_cur_r;
        end else begin
            emit_item.left_out  = SW'({r_prev_l[SW-1], r_prev_l} + ofs_l);
            emit_item.right_out = r_mono ? '0 : SW'({r_prev_r[SW-1], r_prev_r} + ofs_r);
        end
        emit_item.last_of_run = is_last;
        // advance quotient and remainder by one more difference over count
        rs_l   = {1'b0, r_r_l} + {1'b0, r_rd_l};
        rs_r   = {1'b0, r_r_r} + {1'b0, r_rd_r};
        wrap_l = (rs_l >= {1'b0, r_count});
        wrap_r = (rs_r >= {1'b0, r_count});
    end

    // persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_prev_l <= '0;
            r_prev_r <= '0;
        end else begin
            if (r_state == lu48_pkg::ST_PHASE && acc_wrap) begin
                r_phase <= lu48_pkg::RATE_W'(acc_sum - lu48_pkg::OUT_RATE_ACC);
            end
            if (out_load && is_last) begin
                r_prev_l <= r_cur_l;
                if (!r_mono) begin
                    r_prev_r <= r_cur_r;
                end
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cur_l <= i_in_data.left_sample;
            r_cur_r <= in_r;
            r_neg_l <= diff_l[SW];
            r_neg_r <= diff_r[SW];
            r_mag_l <= NW'(diff_l[SW] ? -diff_l : diff_l);
            r_mag_r <= NW'(diff_r[SW] ? -diff_r : diff_r);
            r_acc   <= {1'b0, r_phase};
            r_adds  <= '0;
        end
        if (r_state == lu48_pkg::ST_PHASE) begin
            if (acc_wrap) begin
                r_count <= r_adds;
                r_m     <= '0;
                r_q_l   <= '0;
                r_q_r   <= '0;
                r_r_l   <= '0;
                r_r_r   <= '0;
                r_qd_r  <= '0;
                r_rd_r  <= '0;
            end else begin
                r_acc  <= acc_sum;
                r_adds <= r_adds + 1'b1;
            end
        end
        if (r_state == lu48_pkg::ST_WAIT_L && div_rsp.done) begin
            r_qd_l <= div_rsp.quot;
            r_rd_l <= div_rsp.rem;
        end
        if (r_state == lu48_pkg::ST_WAIT_R && div_rsp.done) begin
            r_qd_r <= div_rsp.quot;
            r_rd_r <= div_rsp.rem;
        end
        if (out_load && !is_last) begin
            r_m   <= r_m + 1'b1;
            r_q_l <= r_q_l + r_qd_l + NW'(wrap_l);
            r_q_r <= r_q_r + r_qd_r + NW'(wrap_r);
            r_r_l <= wrap_l ? CW'(rs_l - {1'b0, r_count}) : rs_l[CW-1:0];
            r_r_r <= wrap_r ? CW'(rs_r - {1'b0, r_count}) : rs_r[CW-1:0];
        end
    end

    // output register: holds a result while the far side stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= emit_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // check helpers
    assign div_wait = (r_state == lu48_pkg::ST_WAIT_L) || (r_state == lu48_pkg::ST_WAIT_R);
    assign run_end  = out_load && is_last;

    // checks
    `LU48_ASSERT_HOLDS(a_phase_range, i_clk, i_rst_n, ({1'b0, r_phase} < lu48_pkg::OUT_RATE_ACC))
    `LU48_ASSERT_IMPLIES(a_div_nonzero, i_clk, i_rst_n, div_req.start, (r_count != '0))
    `LU48_ASSERT_IMPLIES(a_div_done_wait, i_clk, i_rst_n, div_rsp.done, div_wait)
    `LU48_ASSERT_IMPLIES(a_div_busy_wait, i_clk, i_rst_n, div_rsp.busy, div_wait)
    `LU48_ASSERT_NEXT(a_last_to_idle, i_clk, i_rst_n, run_end, (!o_in_stall && r_out.last_of_run))

endmodule

`default_nettype wire

>>> hw/rtl/lu48_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, shared by both channels.
`default_nettype none

module lu48_div (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire lu48_pkg::t_div_req  i_req,
    output lu48_pkg::t_div_rsp       o_rsp
);

    localparam int STEP_W = $clog2(lu48_pkg::DIV_NUM_W);

    logic                           r_busy;
    logic                           r_done;
    logic [STEP_W-1:0]              r_step;
    logic [lu48_pkg::DIV_NUM_W-1:0] r_quo;
    logic [lu48_pkg::DIV_DEN_W-1:0] r_rem;
    logic [lu48_pkg::DIV_DEN_W-1:0] r_den;

    logic [lu48_pkg::DIV_DEN_W:0]   trial;
    logic                           fits;

    // shift in the next dividend bit and try the subtract
    always_comb begin
        trial = {r_rem, r_quo[lu48_pkg::DIV_NUM_W-1]};
        fits  = (trial >= {1'b0, r_den});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(lu48_pkg::DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits shift in where dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[lu48_pkg::DIV_NUM_W-2:0], fits};
            r_rem <= fits ? lu48_pkg::DIV_DEN_W'(trial - {1'b0, r_den})
                          : trial[lu48_pkg::DIV_DEN_W-1:0];
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the linear 48 kHz upsampler core.
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 120;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_PCT      = 22;
    localparam int NUM_PHASES    = 9;
    localparam int PHASE_FRAMES  = 25;

    // spare indexes of the register map, writes there are dropped
    localparam logic [lu48_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = lu48_pkg::CFG_IDX_W'(2);
    localparam logic [lu48_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = lu48_pkg::CFG_IDX_W'(3);

    typedef enum logic {ROW_CFG, ROW_FRAME} t_row_kind;

    typedef struct {
        t_row_kind                          kind;
        logic [lu48_pkg::CFG_IDX_W-1:0]     idx;
        logic [lu48_pkg::CFG_DAT_W-1:0]     data;
        lu48_pkg::t_in_item                 frame;
        int                                 n_typed;
        lu48_pkg::t_out_item                typed0;
        lu48_pkg::t_out_item                typed1;
    } t_stim_row;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_stall;
    lu48_pkg::t_in_item                 in_data;
    logic                               out_valid;
    logic                               out_stall;
    lu48_pkg::t_out_item                out_data;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [lu48_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [lu48_pkg::CFG_DAT_W-1:0]     cfg_data;

    // predictor state and registers
    int unsigned            phase_acc;
    int                     prev_left;
    int                     prev_right;
    int unsigned            rate_reg;
    bit                     mono_reg;

    lu48_pkg::t_out_item    pending_out_frames[$];
    t_stim_row              directed_rows[$];
    int                     mismatch_count;
    int                     cycle_count;
    int                     hold_requests;
    bit                     calm;

    linear_upsampler_to_48khz_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run limit reached", $time);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic lu48_pkg::t_out_item mk_out(input logic [15:0] l,
                                                   input logic [15:0] r,
                                                   input logic last);
        lu48_pkg::t_out_item o;
        o.left_out    = l;
        o.right_out   = r;
        o.last_of_run = last;
        return o;
    endfunction

    // register write as the block sees it
    function automatic void apply_reg(input logic [lu48_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [lu48_pkg::CFG_DAT_W-1:0] data);
        int unsigned r;
        r = data;
        case (idx)
            lu48_pkg::CFG_SOURCE_RATE: begin
                if (r > lu48_pkg::RATE_MAX) r = lu48_pkg::RATE_MAX;
                if (r < lu48_pkg::RATE_MIN) r = lu48_pkg::RATE_MIN;
                rate_reg = r;
            end
            lu48_pkg::CFG_MONO_MODE: mono_reg = data[0];
            default: ;
        endcase
    endfunction

    // phase step and interpolation of one frame; keep=0 only advances the state
    function automatic void upsample_frame(input lu48_pkg::t_in_item f, input bit keep);
        int unsigned acc;
        int          count;
        int          sl;
        int          sr;
        int          dl;
        int          dr;
        int          ol;
        int          orr;
        sl    = $signed(f.left_sample);
        sr    = $signed(f.right_sample);
        acc   = phase_acc;
        count = -1;
        while (acc < lu48_pkg::OUT_RATE_ACC) begin
            count++;
            acc += rate_reg;
        end
        phase_acc = acc - lu48_pkg::OUT_RATE_ACC;
        if (mono_reg) sr = 0;
        if (count < 1) begin
            if (keep) pending_out_frames.push_back(mk_out(sl[15:0], sr[15:0], 1'b1));
        end else begin
            dl = sl - prev_left;
            dr = sr - prev_right;
            for (int m = 0; m <= count; m++) begin
                ol  = prev_left + (dl * m) / count;
                orr = mono_reg ? 0 : prev_right + (dr * m) / count;
                if (keep) pending_out_frames.push_back(mk_out(ol[15:0], orr[15:0], m == count));
            end
        end
        prev_left = sl;
        if (!mono_reg) prev_right = sr;
    endfunction

    function automatic void add_cfg(input logic [lu48_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [lu48_pkg::CFG_DAT_W-1:0] data);
        t_stim_row row;
        row.kind    = ROW_CFG;
        row.idx     = idx;
        row.data    = data;
        row.frame   = '0;
        row.n_typed = 0;
        row.typed0  = '0;
        row.typed1  = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_frame(input logic [15:0] l, input logic [15:0] r,
                                      input int n, input lu48_pkg::t_out_item e0,
                                      input lu48_pkg::t_out_item e1);
        t_stim_row row;
        row.kind    = ROW_FRAME;
        row.idx     = '0;
        row.data    = '0;
        row.frame   = {l, r};
        row.n_typed = n;
        row.typed0  = e0;
        row.typed1  = e1;
        directed_rows.push_back(row);
    endfunction

    // sender: random gaps, then hold the frame until the transfer
    task automatic send_frame(input lu48_pkg::t_in_item f, input int n_typed,
                              input lu48_pkg::t_out_item e0, input lu48_pkg::t_out_item e1);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= f;
        do @(posedge clk); while (in_stall);
        upsample_frame(f, n_typed == 0);
        if (n_typed > 0) pending_out_frames.push_back(e0);
        if (n_typed > 1) pending_out_frames.push_back(e1);
    endtask

    task automatic pause_for_drain();
        in_valid <= 1'b0;
        while (pending_out_frames.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // config writes happen only with the block drained
    task automatic write_reg(input logic [lu48_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lu48_pkg::CFG_DAT_W-1:0] data);
        pause_for_drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg(idx, data);
    endtask

    function automatic logic [lu48_pkg::CFG_DAT_W-1:0] pick_rate();
        case ($urandom_range(0, 9))
            0:       return lu48_pkg::CFG_DAT_W'($urandom_range(0, 65535));
            1:       return lu48_pkg::CFG_DAT_W'($urandom_range(1500, 4000));
            2:       return lu48_pkg::RATE_MAX;
            default: return lu48_pkg::CFG_DAT_W'($urandom_range(8000, 48000));
        endcase
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 7));
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver: random stalls, plus long hold-offs on request
    initial begin
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left   = 0;
        out_stall  <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_requests != hold_served) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (calm || !rst_n) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    task automatic report_mismatch(input string field, input int exp_v, input int act_v);
        mismatch_count++;
        $display("%0t: %s expected %0d actual %0d", $time, field, exp_v, act_v);
    endtask

    // scoreboard: each output transfer against the oldest expectation
    always @(posedge clk) begin
        lu48_pkg::t_out_item exp_o;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_out_frames.size() == 0) begin
                mismatch_count++;
                $display("%0t: output transfer expected none actual left %0d right %0d last %0d",
                         $time, $signed(out_data.left_out), $signed(out_data.right_out),
                         out_data.last_of_run);
            end else begin
                exp_o = pending_out_frames.pop_front();
                if (out_data.left_out !== exp_o.left_out)
                    report_mismatch("left_out", $signed(exp_o.left_out),
                                    $signed(out_data.left_out));
                if (out_data.right_out !== exp_o.right_out)
                    report_mismatch("right_out", $signed(exp_o.right_out),
                                    $signed(out_data.right_out));
                if (out_data.last_of_run !== exp_o.last_of_run)
                    report_mismatch("last_of_run", exp_o.last_of_run, out_data.last_of_run);
            end
        end
    end

    // stimulus
    initial begin
        lu48_pkg::t_in_item  f;
        lu48_pkg::t_out_item z;
        z              = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        hold_requests  = 0;
        calm           = 1'b0;
        phase_acc      = 0;
        prev_left      = 0;
        prev_right     = 0;
        rate_reg       = lu48_pkg::RATE_RESET;
        mono_reg       = 1'b0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;

        // directed table; rows with typed results bypass the predictor output
        add_frame(16'h7FFF, 16'h8000, 2, mk_out(16'h0000, 16'h0000, 1'b0),
                  mk_out(16'h7FFF, 16'h8000, 1'b1));
        add_frame(16'h8000, 16'h7FFF, 0, z, z);
        add_frame(16'h0001, 16'hFFFF, 0, z, z);
        add_cfg(lu48_pkg::CFG_SOURCE_RATE, 16'd0);          // saturates up to the minimum
        add_frame(16'h7FFF, 16'h8000, 0, z, z);
        add_frame(16'h8000, 16'h7FFF, 0, z, z);   // negative left slope, truncation
        add_frame(16'h0005, 16'hFFFB, 0, z, z);
        add_cfg(lu48_pkg::CFG_SOURCE_RATE, 16'd1499);
        add_frame(16'hFFFF, 16'h0001, 0, z, z);
        add_cfg(lu48_pkg::CFG_SOURCE_RATE, 16'hFFFF);       // saturates down to 48000
        add_frame(16'h1234, 16'h8000, 1, mk_out(16'h1234, 16'h8000, 1'b1), z);
        add_frame(16'h7FFF, 16'h7FFF, 1, mk_out(16'h7FFF, 16'h7FFF, 1'b1), z);
        add_cfg(lu48_pkg::CFG_SOURCE_RATE, 16'd48001);
        add_frame(16'h8000, 16'h8000, 1, mk_out(16'h8000, 16'h8000, 1'b1), z);
        add_cfg(lu48_pkg::CFG_SOURCE_RATE, 16'd48000);
        add_frame(16'h0000, 16'h0000, 1, mk_out(16'h0000, 16'h0000, 1'b1), z);
        add_cfg(lu48_pkg::CFG_MONO_MODE, 16'h0001);
        add_frame(16'h4000, 16'h7FFF, 1, mk_out(16'h4000, 16'h0000, 1'b1), z);
        add_cfg(lu48_pkg::CFG_SOURCE_RATE, 16'd1500);
        add_frame(16'h8000, 16'h1234, 0, z, z);
        add_frame(16'h7FFF, 16'h5555, 0, z, z);
        add_cfg(lu48_pkg::CFG_MONO_MODE, 16'hFFFE);         // only bit 0 counts
        add_frame(16'h0100, 16'h0200, 0, z, z);   // right history kept from before mono
        add_cfg(CFG_SPARE_A, 16'hFFFF);
        add_cfg(CFG_SPARE_B, 16'h0001);
        add_frame(16'hAAAA, 16'h5555, 0, z, z);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG)
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            else
                send_frame(directed_rows[i].frame, directed_rows[i].n_typed,
                           directed_rows[i].typed0, directed_rows[i].typed1);
        end

        // random phases, each with fresh register settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(lu48_pkg::CFG_SOURCE_RATE, pick_rate());
            write_reg(lu48_pkg::CFG_MONO_MODE, lu48_pkg::CFG_DAT_W'($urandom));
            calm = (p == 2);
            for (int k = 0; k < PHASE_FRAMES; k++) begin
                if (p == 4 && k == 3) hold_requests++;
                if (p == 6 && k == 12) pause_for_drain();
                f.left_sample  = pick_sample();
                f.right_sample = pick_sample();
                send_frame(f, 0, z, z);
            end
            calm = 1'b0;
        end

        pause_for_drain();
        repeat (END_CYCLES) @(posedge clk);
        foreach (pending_out_frames[i])
            $display("%0t: output transfer expected left %0d right %0d last %0d actual none",
                     $time, $signed(pending_out_frames[i].left_out),
                     $signed(pending_out_frames[i].right_out),
                     pending_out_frames[i].last_of_run);
        mismatch_count += pending_out_frames.size();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
